>>> rtl/ins_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ins_pkg: shared types and constants of the integer nearest scaler
// Field widths, register indexes, clamp limits and the control and status
// structs passed between the sequencer and the address unit.
// ----------------------------------------------------------------------------
package ins_pkg;

  localparam int unsigned MaxScale      = 4;
  localparam int unsigned MaxLinePixels = 2048;
  localparam int unsigned DefWidth      = 320;
  localparam int unsigned DefHeight     = 224;
  localparam int unsigned MaxSrc        = 1024;

  localparam int SrcW    = 11;
  localparam int ScaleW  = 3;
  localparam int OffXW   = 12;
  localparam int OffYW   = 11;
  localparam int PitchW  = 13;
  localparam int ScrHW   = 12;
  localparam int CntW    = 10;
  localparam int ColorW  = 32;
  localparam int AddrW   = 23;
  localparam int LineW   = 14;
  localparam int InlineW = 13;
  localparam int PaddrW  = 5;
  localparam int PdataW  = 32;
  localparam int RegIdxW = 3;

  localparam logic [RegIdxW-1:0] RegSrcWidth  = 3'd0;
  localparam logic [RegIdxW-1:0] RegSrcHeight = 3'd1;
  localparam logic [RegIdxW-1:0] RegScaleX    = 3'd2;
  localparam logic [RegIdxW-1:0] RegScaleY    = 3'd3;
  localparam logic [RegIdxW-1:0] RegOffsetX   = 3'd4;
  localparam logic [RegIdxW-1:0] RegOffsetY   = 3'd5;
  localparam logic [RegIdxW-1:0] RegPitch     = 3'd6;
  localparam logic [RegIdxW-1:0] RegScrHeight = 3'd7;

  // Effective settings after the zero-size default and the clamps.
  typedef struct packed {
    logic [SrcW-1:0]   width;
    logic [SrcW-1:0]   height;
    logic [ScaleW-1:0] sxf;
    logic [ScaleW-1:0] syf;
    logic [OffXW-1:0]  off_x;
    logic [OffYW-1:0]  off_y;
    logic [PitchW-1:0] pitch;
    logic [ScrHW-1:0]  scr_h;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic mul;
    logic step_x;
    logic step_y;
  } agu_ctrl_t;

  typedef struct packed {
    logic line_ok;
    logic line_next_ok;
    logic inline_ok;
    logic inline_next_ok;
  } agu_stat_t;

endpackage

>>> rtl/ins_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ins_if: stream interfaces of the integer nearest scaler
// pix_if carries source pixels, wr_if carries framebuffer writes.
// ----------------------------------------------------------------------------
interface pix_if;
  import ins_pkg::*;

  logic              valid;
  logic              ready;
  logic [ColorW-1:0] pixel_color;

  modport source (output valid, output pixel_color, input ready);
  modport sink   (input valid, input pixel_color, output ready);
endinterface

interface wr_if;
  import ins_pkg::*;

  logic              valid;
  logic              ready;
  logic [AddrW-1:0]  dest_address;
  logic [ColorW-1:0] dest_color;
  logic              last_write;

  modport source (output valid, output dest_address, output dest_color,
                  output last_write, input ready);
  modport sink   (input valid, input dest_address, input dest_color,
                  input last_write, output ready);
endinterface

>>> rtl/ins_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ins_cfg: configuration registers
// APB register file with read-back, plus the decoded effective settings.
// ----------------------------------------------------------------------------
module ins_cfg (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ins_pkg::PaddrW-1:0] paddr,
  input  logic [ins_pkg::PdataW-1:0] pwdata,
  output logic [ins_pkg::PdataW-1:0] prdata,
  output logic                       pready,
  output ins_pkg::cfg_t              cfg_o
);
  import ins_pkg::*;

  logic [SrcW-1:0]    src_w_q, src_h_q;
  logic [ScaleW-1:0]  scl_x_q, scl_y_q;
  logic [OffXW-1:0]   off_x_q;
  logic [OffYW-1:0]   off_y_q;
  logic [PitchW-1:0]  pitch_q;
  logic [ScrHW-1:0]   scr_h_q;
  logic               wr_en;
  logic [RegIdxW-1:0] idx;
  logic [SrcW-1:0]    w_raw, h_raw;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = paddr[PaddrW-1:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_w_q <= SrcW'(DefWidth);
      src_h_q <= SrcW'(DefHeight);
      scl_x_q <= ScaleW'(1);
      scl_y_q <= ScaleW'(1);
      off_x_q <= '0;
      off_y_q <= '0;
      pitch_q <= PitchW'(1024);
      scr_h_q <= ScrHW'(768);
    end else if (wr_en) begin
      case (idx)
        RegSrcWidth:  src_w_q <= pwdata[SrcW-1:0];
        RegSrcHeight: src_h_q <= pwdata[SrcW-1:0];
        RegScaleX:    scl_x_q <= pwdata[ScaleW-1:0];
        RegScaleY:    scl_y_q <= pwdata[ScaleW-1:0];
        RegOffsetX:   off_x_q <= pwdata[OffXW-1:0];
        RegOffsetY:   off_y_q <= pwdata[OffYW-1:0];
        RegPitch:     pitch_q <= pwdata[PitchW-1:0];
        RegScrHeight: scr_h_q <= pwdata[ScrHW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      RegSrcWidth:  prdata = PdataW'(src_w_q);
      RegSrcHeight: prdata = PdataW'(src_h_q);
      RegScaleX:    prdata = PdataW'(scl_x_q);
      RegScaleY:    prdata = PdataW'(scl_y_q);
      RegOffsetX:   prdata = PdataW'(off_x_q);
      RegOffsetY:   prdata = PdataW'(off_y_q);
      RegPitch:     prdata = PdataW'(pitch_q);
      RegScrHeight: prdata = PdataW'(scr_h_q);
      default:      prdata = '0;
    endcase
  end

  function automatic logic [ScaleW-1:0] clamp_scale(input logic [ScaleW-1:0] s);
    logic [ScaleW-1:0] r;
    if (s == '0) r = ScaleW'(1);
    else if (32'(s) > MaxScale) r = ScaleW'(MaxScale);
    else r = s;
    return r;
  endfunction

  // Zero in either dimension selects the default frame for both.
  always_comb begin
    if (src_w_q == '0 || src_h_q == '0) begin
      w_raw = SrcW'(DefWidth);
      h_raw = SrcW'(DefHeight);
    end else begin
      w_raw = src_w_q;
      h_raw = src_h_q;
    end
    cfg_o.width  = (32'(w_raw) > MaxSrc) ? SrcW'(MaxSrc) : w_raw;
    cfg_o.height = (32'(h_raw) > MaxSrc) ? SrcW'(MaxSrc) : h_raw;
    cfg_o.sxf    = clamp_scale(scl_x_q);
    cfg_o.syf    = clamp_scale(scl_y_q);
    cfg_o.off_x  = off_x_q;
    cfg_o.off_y  = off_y_q;
    cfg_o.pitch  = pitch_q;
    cfg_o.scr_h  = scr_h_q;
  end

endmodule

>>> rtl/ins_agu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ins_agu: address generation unit
// Holds the current destination line, its base address and the in-line
// position; its adders walk them write by write.
// ----------------------------------------------------------------------------
module ins_agu (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  ins_pkg::cfg_t               cfg_i,
  input  ins_pkg::agu_ctrl_t          ctrl_i,
  input  logic [ins_pkg::CntW-1:0]    col_i,
  input  logic [ins_pkg::CntW-1:0]    row_i,
  output ins_pkg::agu_stat_t          stat_o,
  output logic [ins_pkg::AddrW-1:0]   addr_o
);
  import ins_pkg::*;

  logic [LineW-1:0]        line_q;
  logic [AddrW-1:0]        line_addr_q;
  logic [InlineW-1:0]      inline_q, inline_base_q;
  logic [LineW+PitchW-1:0] prod;

  assign prod = (LineW+PitchW)'(line_q) * (LineW+PitchW)'(cfg_i.pitch);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_q        <= '0;
      line_addr_q   <= '0;
      inline_q      <= '0;
      inline_base_q <= '0;
    end else begin
      if (ctrl_i.load) begin
        line_q        <= LineW'(cfg_i.off_y) + LineW'(row_i) * LineW'(cfg_i.syf);
        inline_q      <= InlineW'(col_i) * InlineW'(cfg_i.sxf);
        inline_base_q <= InlineW'(col_i) * InlineW'(cfg_i.sxf);
      end
      if (ctrl_i.mul) begin
        line_addr_q <= prod[AddrW-1:0];
      end
      if (ctrl_i.step_x) begin
        inline_q <= inline_q + InlineW'(1);
      end
      // Next destination line: rewind to the block's left edge.
      if (ctrl_i.step_y) begin
        line_q      <= line_q + LineW'(1);
        line_addr_q <= line_addr_q + AddrW'(cfg_i.pitch);
        inline_q    <= inline_base_q;
      end
    end
  end

  assign addr_o = line_addr_q + AddrW'(cfg_i.off_x) + AddrW'(inline_q);

  assign stat_o.line_ok        = line_q < LineW'(cfg_i.scr_h);
  assign stat_o.line_next_ok   = (LineW+1)'(line_q) + (LineW+1)'(1) <
                                 (LineW+1)'(cfg_i.scr_h);
  assign stat_o.inline_ok      = (InlineW+1)'(inline_q) < (InlineW+1)'(MaxLinePixels);
  assign stat_o.inline_next_ok = (InlineW+1)'(inline_q) + (InlineW+1)'(1) <
                                 (InlineW+1)'(MaxLinePixels);

endmodule

>>> rtl/ins_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ins_seq: pixel sequencer
// Accepts one pixel, keeps the source column and row, steps the address
// unit over the replicated block and drives the write output register.
// ----------------------------------------------------------------------------
module ins_seq (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  ins_pkg::cfg_t              cfg_i,
  pix_if.sink                        pix_i,
  wr_if.source                       wr_o,
  output ins_pkg::agu_ctrl_t         ctrl_o,
  input  ins_pkg::agu_stat_t         stat_i,
  input  logic [ins_pkg::AddrW-1:0]  addr_i,
  output logic [ins_pkg::CntW-1:0]   col_o,
  output logic [ins_pkg::CntW-1:0]   row_o
);
  import ins_pkg::*;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StMul  = 2'd1;
  localparam logic [1:0] StEmit = 2'd2;

  logic [1:0]        state_q, state_d;
  logic [CntW-1:0]   col_q, col_d, row_q, row_d;
  logic [ScaleW-1:0] sx_q, sx_d, sy_q, sy_d;
  logic [ColorW-1:0] color_q;
  logic              ov_q, ov_d;
  logic [AddrW-1:0]  oaddr_q;
  logic [ColorW-1:0] ocolor_q;
  logic              olast_q;
  logic              accept, fire, end_x, last;

  assign pix_i.ready = (state_q == StIdle);
  assign accept      = pix_i.valid && pix_i.ready;
  assign fire        = (state_q == StEmit) && (!ov_q || wr_o.ready);

  assign end_x = ((ScaleW+1)'(sx_q) + (ScaleW+1)'(1) == (ScaleW+1)'(cfg_i.sxf)) ||
                 !stat_i.inline_next_ok;
  assign last  = end_x &&
                 (((ScaleW+1)'(sy_q) + (ScaleW+1)'(1) == (ScaleW+1)'(cfg_i.syf)) ||
                  !stat_i.line_next_ok);

  always_comb begin
    state_d       = state_q;
    col_d         = col_q;
    row_d         = row_q;
    sx_d          = sx_q;
    sy_d          = sy_q;
    ctrl_o        = '0;
    ov_d          = ov_q;
    if (ov_q && wr_o.ready) ov_d = 1'b0;
    case (state_q)
      StIdle: begin
        if (accept) begin
          ctrl_o.load = 1'b1;
          sx_d        = '0;
          sy_d        = '0;
          state_d     = StMul;
          // Advance the source position; wrap against the current frame size.
          if ((SrcW)'(col_q) + SrcW'(1) >= cfg_i.width) begin
            col_d = '0;
            if ((SrcW)'(row_q) + SrcW'(1) >= cfg_i.height) row_d = '0;
            else row_d = row_q + CntW'(1);
          end else begin
            col_d = col_q + CntW'(1);
          end
        end
      end
      StMul: begin
        ctrl_o.mul = 1'b1;
        // Drop the pixel when its first write is already off limits.
        state_d = (stat_i.line_ok && stat_i.inline_ok) ? StEmit : StIdle;
      end
      StEmit: begin
        if (fire) begin
          ov_d = 1'b1;
          if (last) begin
            state_d = StIdle;
          end else if (end_x) begin
            ctrl_o.step_y = 1'b1;
            sx_d          = '0;
            sy_d          = sy_q + ScaleW'(1);
          end else begin
            ctrl_o.step_x = 1'b1;
            sx_d          = sx_q + ScaleW'(1);
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      col_q   <= '0;
      row_q   <= '0;
      sx_q    <= '0;
      sy_q    <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      col_q   <= col_d;
      row_q   <= row_d;
      sx_q    <= sx_d;
      sy_q    <= sy_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) color_q <= pix_i.pixel_color;
    if (fire) begin
      oaddr_q  <= addr_i;
      ocolor_q <= color_q;
      olast_q  <= last;
    end
  end

  assign col_o           = col_q;
  assign row_o           = row_q;
  assign wr_o.valid      = ov_q;
  assign wr_o.dest_address = oaddr_q;
  assign wr_o.dest_color = ocolor_q;
  assign wr_o.last_write = olast_q;

endmodule

>>> rtl/integer_nearest_scaler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_nearest_scaler: nearest-neighbor integer upscaler with centering
// Source pixels in, replicated framebuffer writes out.
// ----------------------------------------------------------------------------
// Source pixels arrive in raster order on pix_i; each one becomes a block of
// up to scale_x by scale_y writes on wr_o at
// (offset_y + row*scale_y + sy)*line_pitch + offset_x + col*scale_x + sx,
// line by line within the block, with last_write marking the block's final
// beat. Destination lines at or beyond screen_height and positions past the
// line buffer width are not written; a pixel left with no writes still
// advances the column and row counters. Each pixel, of at most 16 writes,
// passes in order through taking the beat, the line-times-pitch multiply
// and the write steps, with one write per cycle from the address unit while
// the write output is not stalled. Settings are written over APB and must
// only change while no pixel is in flight.
// ----------------------------------------------------------------------------
module integer_nearest_scaler (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  pix_if.sink                        pix_i,
  wr_if.source                       wr_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ins_pkg::PaddrW-1:0] paddr,
  input  logic [ins_pkg::PdataW-1:0] pwdata,
  output logic [ins_pkg::PdataW-1:0] prdata,
  output logic                       pready
);
  import ins_pkg::*;

  cfg_t                cfg;
  agu_ctrl_t           agu_ctrl;
  agu_stat_t           agu_stat;
  logic [AddrW-1:0]    agu_addr;
  logic [CntW-1:0]     col, row;

  // Register file and effective settings.
  ins_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Sequencer: handshakes, source position and write output register.
  ins_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .pix_i  (pix_i),
    .wr_o   (wr_o),
    .ctrl_o (agu_ctrl),
    .stat_i (agu_stat),
    .addr_i (agu_addr),
    .col_o  (col),
    .row_o  (row)
  );

  // Shared address unit, stepped after each write but a block's last.
  ins_agu u_agu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .ctrl_i (agu_ctrl),
    .col_i  (col),
    .row_i  (row),
    .stat_o (agu_stat),
    .addr_o (agu_addr)
  );

endmodule

>>> rtl/ins_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ins_chk: port checker for the integer nearest scaler
// Watches the stream and APB ports and flags handshake or sequencing slips.
// ----------------------------------------------------------------------------
module ins_chk (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_ready_i,
  input logic                       out_valid_i,
  input logic                       out_ready_i,
  input logic [ins_pkg::AddrW-1:0]  out_addr_i,
  input logic [ins_pkg::ColorW-1:0] out_color_i,
  input logic                       out_last_i,
  input logic                       pready_i
);
  import ins_pkg::*;

  // A stalled write beat holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_addr_i) &&
    $stable(out_color_i) && $stable(out_last_i))
    else $error("write beat changed while stalled");

  // Busy during the multiply step that follows a pixel beat.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("pixel taken back to back");

  // Only a pixel's final write may still wait while a new pixel is taken.
  a_last_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_i && out_valid_i |-> out_last_i)
    else $error("ready while a pixel block is unfinished");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pready_i)
    else $error("pready low");

endmodule

bind integer_nearest_scaler ins_chk u_ins_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (pix_i.valid),
  .in_ready_i  (pix_i.ready),
  .out_valid_i (wr_o.valid),
  .out_ready_i (wr_o.ready),
  .out_addr_i  (wr_o.dest_address),
  .out_color_i (wr_o.dest_color),
  .out_last_i  (wr_o.last_write),
  .pready_i    (pready)
);
